### hdl/ptc_pkg.sv
package ptc_pkg;

  // Tree geometry (bottom-up layout: leaf i at node LEAVES+i, root at node 1).
  // LEAVES is a power of two.
  localparam int LEAVES     = 1024;
  localparam int KEY_BITS   = 10;
  localparam int NODE_COUNT = 2 * LEAVES;
  localparam int NODE_BITS  = $clog2(NODE_COUNT);
  localparam int LEVELS     = $clog2(LEAVES) + 1;
  localparam int LEVEL_BITS = $clog2(LEVELS);

  // Counter and result widths (node count width equals the prefix_count width)
  localparam int COUNT_BITS = 16;
  localparam int OUT_BITS   = 16;
  localparam int TOTAL_BITS = 32;

  // Epoch tag stored with every node; a stale tag reads as zero
  localparam int EPOCH_BITS = 6;
  localparam int WORD_BITS  = EPOCH_BITS + COUNT_BITS;

  localparam logic [KEY_BITS-1:0]  TOP_RESET = KEY_BITS'(1023);
  localparam logic [NODE_BITS-1:0] ROOT_NODE = NODE_BITS'(1);

  typedef struct packed {
    logic [KEY_BITS-1:0] key_index;
    logic                restart;
  } in_item_t;

  typedef struct packed {
    logic [OUT_BITS-1:0]   prefix_count;
    logic [TOTAL_BITS-1:0] running_total;
  } out_item_t;

  typedef struct packed {
    logic [EPOCH_BITS-1:0] epoch;
    logic [COUNT_BITS-1:0] count;
  } node_word_t;

endpackage

### hdl/ptc_ram.sv
module ptc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  output logic [WIDTH-1:0]         rdata_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port, two registered read ports
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

### hdl/prefix_count_tree_counter.sv
// Flow: after a beat is accepted, the item walks the 11 tree levels through the node
//   memory, one level at a time, then passes a tail state and a finish state.
// Flow control: no new beat is accepted until the current item has loaded its result.
// Reset: a clearing pass over all 2048 node memory words, no beat accepted meanwhile.
// A restart bumps an epoch tag; every 64th restart repeats the clearing pass.
module prefix_count_tree_counter (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  ptc_pkg::in_item_t              in_data,
  output logic                           out_valid,
  input  logic                           out_ready,
  output ptc_pkg::out_item_t             out_data,
  input  logic                           cfg_we,
  input  logic [ptc_pkg::KEY_BITS-1:0]   cfg_wdata
);
  import ptc_pkg::*;

  typedef enum logic [2:0] {ST_IDLE, ST_CLEAR, ST_WALK, ST_TAIL, ST_FINISH} state_t;

  state_t                  state;
  logic                    item_held;
  logic [KEY_BITS-1:0]     highest_index;
  logic [EPOCH_BITS-1:0]   epoch;
  logic [NODE_BITS-1:0]    clr_addr;
  logic [LEVEL_BITS-1:0]   level;
  logic [NODE_BITS-1:0]    path_node;
  logic [NODE_BITS:0]      lo_bound;
  logic [NODE_BITS:0]      hi_bound;
  logic [COUNT_BITS-1:0]   sum;
  logic [TOTAL_BITS-1:0]   total_acc;
  logic                    s1_valid;
  logic                    s1_flag_a;
  logic                    s1_flag_b;
  logic [NODE_BITS-1:0]    s1_node;

  logic [KEY_BITS-1:0]     top_eff;
  logic [KEY_BITS-1:0]     key_clamped;
  logic [NODE_BITS-1:0]    leaf_node;
  logic                    in_range;
  logic                    flag_a;
  logic                    flag_b;
  logic [NODE_BITS-1:0]    rd_addr_a;
  logic [NODE_BITS-1:0]    rd_addr_b;
  logic [WORD_BITS-1:0]    rd_data_a;
  logic [WORD_BITS-1:0]    rd_data_b;
  node_word_t              word_a;
  node_word_t              word_b;
  logic [COUNT_BITS-1:0]   cnt_a;
  logic [COUNT_BITS-1:0]   cnt_b;
  logic [COUNT_BITS-1:0]   inc_a;
  logic [COUNT_BITS+1:0]   sum_wide;
  logic [COUNT_BITS-1:0]   sum_sat;
  logic [TOTAL_BITS:0]     total_wide;
  logic [TOTAL_BITS-1:0]   total_sat;
  logic                    load_out;
  logic                    ram_we;
  logic [NODE_BITS-1:0]    ram_waddr;
  node_word_t              ram_wdata;

  // Clamp the key to the top index in use
  always_comb begin
    top_eff = highest_index;
    if (int'(highest_index) > LEAVES - 1) begin
      top_eff = KEY_BITS'(LEAVES - 1);
    end
    key_clamped = (in_data.key_index > top_eff) ? top_eff : in_data.key_index;
    leaf_node   = NODE_BITS'(LEAVES) + NODE_BITS'(key_clamped);
  end

  assign in_ready = (state == ST_IDLE);

  // Issue one tree level per cycle: port A walks the insert path (it also
  // covers the low bound, which is a power of two and odd only at the root),
  // port B reads the node left of the high bound.
  assign in_range  = (lo_bound < hi_bound);
  assign flag_a    = in_range & lo_bound[0];
  assign flag_b    = in_range & hi_bound[0];
  assign rd_addr_a = path_node;
  assign rd_addr_b = NODE_BITS'(hi_bound - (NODE_BITS + 1)'(1));

  // Drop counts whose epoch tag is stale
  always_comb begin
    word_a = node_word_t'(rd_data_a);
    word_b = node_word_t'(rd_data_b);
    cnt_a  = (word_a.epoch == epoch) ? word_a.count : '0;
    cnt_b  = (word_b.epoch == epoch) ? word_b.count : '0;
    inc_a  = (&cnt_a) ? cnt_a : cnt_a + COUNT_BITS'(1);
    sum_wide = {2'b00, sum}
             + (s1_flag_a ? {2'b00, cnt_a} : '0)
             + (s1_flag_b ? {2'b00, cnt_b} : '0);
    sum_sat  = (|sum_wide[COUNT_BITS+1:COUNT_BITS]) ? '1 : sum_wide[COUNT_BITS-1:0];
  end

  // Saturating running total
  assign total_wide = {1'b0, total_acc} + (TOTAL_BITS + 1)'(sum);
  assign total_sat  = total_wide[TOTAL_BITS] ? '1 : total_wide[TOTAL_BITS-1:0];
  assign load_out   = (state == ST_FINISH) && (!out_valid || out_ready);

  // Write port: clearing pass, else the saturating increment along the path
  always_comb begin
    if (state == ST_CLEAR) begin
      ram_we          = 1'b1;
      ram_waddr       = clr_addr;
      ram_wdata.epoch = epoch;
      ram_wdata.count = '0;
    end else begin
      ram_we          = s1_valid;
      ram_waddr       = s1_node;
      ram_wdata.epoch = epoch;
      ram_wdata.count = inc_a;
    end
  end

  ptc_ram #(
    .WIDTH (WORD_BITS),
    .DEPTH (NODE_COUNT)
  ) u_node_ram (
    .clk     (clk),
    .we      (ram_we),
    .waddr   (ram_waddr),
    .wdata   (ram_wdata),
    .raddr_a (rd_addr_a),
    .rdata_a (rd_data_a),
    .raddr_b (rd_addr_b),
    .rdata_b (rd_data_b)
  );

  // Sequencer, accumulators and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_CLEAR;
      clr_addr      <= '0;
      item_held     <= 1'b0;
      epoch         <= '0;
      highest_index <= TOP_RESET;
      total_acc     <= '0;
      out_valid     <= 1'b0;
      s1_valid      <= 1'b0;
      level         <= '0;
    end else begin
      if (cfg_we) begin
        highest_index <= cfg_wdata;
      end
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end

      // Hold the level issued this cycle for the read-modify-write next cycle
      s1_valid  <= (state == ST_WALK);
      s1_flag_a <= flag_a;
      s1_flag_b <= flag_b;
      s1_node   <= path_node;
      if (s1_valid) begin
        sum <= sum_sat;
      end

      unique case (state)
        ST_IDLE: begin
          if (in_valid) begin
            path_node <= leaf_node;
            lo_bound  <= (NODE_BITS + 1)'(LEAVES);
            hi_bound  <= {1'b0, leaf_node} + (NODE_BITS + 1)'(1);
            sum       <= '0;
            level     <= '0;
            state     <= ST_WALK;
            if (in_data.restart) begin
              total_acc <= '0;
              epoch     <= epoch + EPOCH_BITS'(1);
              // Tags are about to alias: sweep the memory first
              if (&epoch) begin
                clr_addr  <= '0;
                item_held <= 1'b1;
                state     <= ST_CLEAR;
              end
            end
          end
        end
        ST_CLEAR: begin
          clr_addr <= clr_addr + NODE_BITS'(1);
          if (&clr_addr) begin
            item_held <= 1'b0;
            state     <= item_held ? ST_WALK : ST_IDLE;
          end
        end
        ST_WALK: begin
          path_node <= path_node >> 1;
          lo_bound  <= lo_bound >> 1;
          hi_bound  <= hi_bound >> 1;
          level     <= level + LEVEL_BITS'(1);
          if (level == LEVEL_BITS'(LEVELS - 1)) begin
            state <= ST_TAIL;
          end
        end
        ST_TAIL: begin
          state <= ST_FINISH;
        end
        ST_FINISH: begin
          if (load_out) begin
            out_valid              <= 1'b1;
            out_data.prefix_count  <= OUT_BITS'(sum);
            out_data.running_total <= total_sat;
            total_acc              <= total_sat;
            state                  <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // The write of one level never targets a node read for the next level
  a_no_rw_clash: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && state == ST_WALK) |-> (s1_node != rd_addr_a && s1_node != rd_addr_b))
    else $error("node write collides with a read of the same cycle");

  // The low bound only contributes at the root
  a_low_at_root: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && s1_flag_a) |-> (s1_node == ROOT_NODE))
    else $error("low-bound contribution away from the root");

  // The running total never falls within a run
  a_total_grows: assert property (@(posedge clk) disable iff (rst)
    load_out |-> (total_sat >= total_acc))
    else $error("running total decreased");

  // One item in flight at a time
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("second beat accepted while an item is in work");

endmodule
